/* sv/bus_node_address_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bus node address allocator
// Immediate-implication and next-cycle-implication checks on the main clock.
// ----------------------------------------------------------------------------
`ifndef BUS_NODE_ADDRESS_ALLOCATOR_MACROS_SVH
`define BUS_NODE_ADDRESS_ALLOCATOR_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define BNA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// antecedent holds -> consequent holds in the next cycle
`define BNA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

/* sv/bna_pkg.sv */
// ----------------------------------------------------------------------------
// bna_pkg
// Shared constants, command codes, types and encoders of the address allocator.
// ----------------------------------------------------------------------------
package bna_pkg;

   localparam int ADDRESS_LIMIT = 127;
   // addresses are 7 bits and 127 is the "none" code
   localparam int LIM           = (ADDRESS_LIMIT > 127) ? 127 : ADDRESS_LIMIT;
   localparam int ADDR_W        = 7;
   localparam int ID_W          = 8;
   localparam int CNT_W         = 8;
   localparam int DEPTH         = 128;
   localparam int GROUP_W       = 8;
   localparam int N_GROUPS      = DEPTH / GROUP_W;
   localparam int POS_W         = 3;
   localparam int GRP_W         = 4;

   localparam logic [ADDR_W-1:0] NONE_ADDR = 7'h7F;
   localparam logic [CNT_W-1:0]  LIM_CNT   = CNT_W'(LIM);

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP  = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } bna_cmd_type;

   function automatic logic [DEPTH-1:0] legal_mask();
      logic [DEPTH-1:0] m;
      m = '0;
      for (int i = 1; i < LIM; i++) begin
         m[i] = 1'b1;
      end
      return m;
   endfunction

   localparam logic [DEPTH-1:0] LEGAL_MASK = legal_mask();

   function automatic logic [POS_W-1:0] first8(input logic [GROUP_W-1:0] v);
      logic [POS_W-1:0] r;
      r = '0;
      for (int i = GROUP_W - 1; i >= 0; i--) begin
         if (v[i]) r = POS_W'(i);
      end
      return r;
   endfunction

   function automatic logic [GRP_W-1:0] first16(input logic [N_GROUPS-1:0] v);
      logic [GRP_W-1:0] r;
      r = '0;
      for (int i = N_GROUPS - 1; i >= 0; i--) begin
         if (v[i]) r = GRP_W'(i);
      end
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] a);
      logic [CNT_W-1:0] s;
      s = {1'b0, a} + CNT_W'(1);
      return (s >= LIM_CNT) ? ADDR_W'(1) : s[ADDR_W-1:0];
   endfunction

endpackage

/* sv/bna_req_if.sv */
// ----------------------------------------------------------------------------
// bna_req_if
// Request channel: command, node id and target address with valid/ready.
// ----------------------------------------------------------------------------
interface bna_req_if import bna_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [ID_W-1:0]   node_id;
   logic [ADDR_W-1:0] target_address;

   modport source (output valid, cmd, node_id, target_address, input ready);
   modport sink   (input valid, cmd, node_id, target_address, output ready);
endinterface

/* sv/bna_rsp_if.sv */
// ----------------------------------------------------------------------------
// bna_rsp_if
// Response channel: allocated address, stored id, hit and full flags.
// ----------------------------------------------------------------------------
interface bna_rsp_if import bna_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] given_address;
   logic [ID_W-1:0]   stored_id;
   logic              hit;
   logic              table_full;

   modport source (output valid, given_address, stored_id, hit, table_full, input ready);
   modport sink   (input valid, given_address, stored_id, hit, table_full, output ready);
endinterface

/* sv/bna_ctrl.sv */
// ----------------------------------------------------------------------------
// bna_ctrl
// Sequencer: accept, scan, commit; owns both handshakes.
// ----------------------------------------------------------------------------
module bna_ctrl import bna_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output bna_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       commit;
   logic       accept;

   // commit needs the output register free
   assign commit    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || commit;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (commit) state_in = accept ? ST_SCAN : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = accept;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.commit = commit;

endmodule

/* sv/bna_dpath.sv */
// ----------------------------------------------------------------------------
// bna_dpath
// Occupancy map, id memory, two-level free-slot search and result register.
// ----------------------------------------------------------------------------
module bna_dpath import bna_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  bna_cmd_type       cmd,
   input  logic [1:0]        req_cmd,
   input  logic [ID_W-1:0]   req_node_id,
   input  logic [ADDR_W-1:0] req_target_address,
   output logic [ADDR_W-1:0] rsp_given_address,
   output logic [ID_W-1:0]   rsp_stored_id,
   output logic              rsp_hit,
   output logic              rsp_table_full
);

   localparam logic [DEPTH-1:0] OCC_RESET = DEPTH'(1);

   // held item
   logic [1:0]        op_ff;
   logic [ID_W-1:0]   nid_ff;
   logic [ADDR_W-1:0] tgt_ff;

   // table state
   logic [DEPTH-1:0]  occ_ff, occ_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ID_W-1:0]   id_mem [DEPTH];
   logic [ID_W-1:0]   rd_ff;

   // search stage registers
   logic [N_GROUPS-1:0] hi_any_ff, lo_any_ff;
   logic [POS_W-1:0]    hi_pos_ff [N_GROUPS];
   logic [POS_W-1:0]    lo_pos_ff [N_GROUPS];

   // result register
   logic [ADDR_W-1:0] given_ff, given_in;
   logic [ID_W-1:0]   sid_ff, sid_in;
   logic              hit_ff, hit_in;
   logic              full_ff;

   // scan: free slots, and those at or past the pointer
   logic [ADDR_W-1:0] p_eff;
   logic [DEPTH-1:0]  free_vec, hi_vec;

   always_comb begin
      p_eff = ((ptr_ff == '0) || ({1'b0, ptr_ff} >= LIM_CNT)) ? ADDR_W'(1) : ptr_ff;
      for (int i = 0; i < DEPTH; i++) begin
         free_vec[i] = !occ_ff[i] && LEGAL_MASK[i];
         hi_vec[i]   = free_vec[i] && (CNT_W'(i) >= {1'b0, p_eff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_cmd;
         nid_ff <= req_node_id;
         tgt_ff <= req_target_address;
      end
      if (cmd.scan) begin
         rd_ff <= id_mem[tgt_ff];
         for (int g = 0; g < N_GROUPS; g++) begin
            hi_any_ff[g] <= |hi_vec[g*GROUP_W +: GROUP_W];
            lo_any_ff[g] <= |free_vec[g*GROUP_W +: GROUP_W];
            hi_pos_ff[g] <= first8(hi_vec[g*GROUP_W +: GROUP_W]);
            lo_pos_ff[g] <= first8(free_vec[g*GROUP_W +: GROUP_W]);
         end
      end
   end

   // commit: pick group, then slot within it
   logic                use_hi;
   logic [N_GROUPS-1:0] flags;
   logic [GRP_W-1:0]    grp;
   logic [POS_W-1:0]    pos;
   logic [ADDR_W-1:0]   alloc_addr;
   logic                found;
   logic                tgt_occ;
   logic                do_write;

   always_comb begin
      use_hi     = |hi_any_ff;
      flags      = use_hi ? hi_any_ff : lo_any_ff;
      grp        = first16(flags);
      pos        = use_hi ? hi_pos_ff[grp] : lo_pos_ff[grp];
      alloc_addr = {grp, pos};
      found      = |lo_any_ff;
      tgt_occ    = ({1'b0, tgt_ff} < LIM_CNT) && occ_ff[tgt_ff];

      occ_in   = occ_ff;
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      given_in = NONE_ADDR;
      sid_in   = '0;
      hit_in   = 1'b0;
      do_write = 1'b0;

      unique case (op_ff)
         CMD_ALLOC: begin
            if ((cnt_ff < LIM_CNT) && found) begin
               occ_in[alloc_addr] = 1'b1;
               cnt_in             = cnt_ff + CNT_W'(1);
               ptr_in             = wrap_next(alloc_addr);
               given_in           = alloc_addr;
               do_write           = 1'b1;
            end
         end
         CMD_RELEASE: begin
            hit_in = tgt_occ;
            // upstream route entry stays put
            if (tgt_occ && (tgt_ff != '0)) begin
               occ_in[tgt_ff] = 1'b0;
               cnt_in         = cnt_ff - CNT_W'(1);
            end
         end
         CMD_LOOKUP: begin
            hit_in = tgt_occ;
            // entry 0 is never written and reads as zero
            if (tgt_occ && (tgt_ff != '0)) sid_in = rd_ff;
         end
         CMD_CLEAR: begin
            occ_in = OCC_RESET;
            ptr_in = ADDR_W'(1);
            cnt_in = CNT_W'(1);
         end
         default: begin
            occ_in = occ_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_write) id_mem[alloc_addr] <= nid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= OCC_RESET;
         ptr_ff <= ADDR_W'(1);
         cnt_ff <= CNT_W'(1);
      end else if (cmd.commit) begin
         occ_ff <= occ_in;
         ptr_ff <= ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         given_ff <= given_in;
         sid_ff   <= sid_in;
         hit_ff   <= hit_in;
         full_ff  <= (cnt_in >= LIM_CNT);
      end
   end

   assign rsp_given_address = given_ff;
   assign rsp_stored_id     = sid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_table_full    = full_ff;

endmodule

/* sv/bus_node_address_allocator.sv */
// ----------------------------------------------------------------------------
// bus_node_address_allocator
// Round-robin allocator of logical bus addresses with id store and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one command item: allocate, release, look up or clear,
//   with the node id and target address. rsp_ch returns one result item per
//   command: given address (127 = none), stored id, hit and table-full flags.
//   From request accept to response valid, the item is latched at the accept
//   edge, the scan state reads the occupancy map into per-group search
//   registers (and reads the id memory), and the commit state picks the slot
//   and commits.
//   The scan/commit pair of the two-level free-slot search paces the items;
//   the next item is taken in the commit cycle. The result sits in an output
//   register, so one item is taken while a result waits; if the receiver
//   keeps stalling, the commit waits and req_ch.ready stays low until the
//   output register frees.
//   Reset leaves address 0 occupied, the pointer at 1 and the count at 1;
//   the clear command does the same in one item, without a clearing pass.
// ----------------------------------------------------------------------------
`include "bus_node_address_allocator_macros.svh"

module bus_node_address_allocator import bna_pkg::*; (
   input logic clock,
   input logic reset,
   bna_req_if.sink   req_ch,
   bna_rsp_if.source rsp_ch
);

   bna_cmd_type cmd;

   bna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   bna_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_cmd            (req_ch.cmd),
      .req_node_id        (req_ch.node_id),
      .req_target_address (req_ch.target_address),
      .rsp_given_address  (rsp_ch.given_address),
      .rsp_stored_id      (rsp_ch.stored_id),
      .rsp_hit            (rsp_ch.hit),
      .rsp_table_full     (rsp_ch.table_full)
   );

   `BNA_ASSERT_NEXT(a_accept_then_scan, clock, reset, cmd.load, cmd.scan && !cmd.commit)
   `BNA_ASSERT_SAME(a_commit_after_scan, clock, reset, cmd.commit, !cmd.scan)
   `BNA_ASSERT_SAME(a_no_accept_in_scan, clock, reset, cmd.scan, !req_ch.ready)
   `BNA_ASSERT_NEXT(a_commit_shows_rsp, clock, reset, cmd.commit, rsp_ch.valid)

endmodule

/* dv/tb_bus_node_address_allocator.sv */
// ----------------------------------------------------------------------------
// tb_bus_node_address_allocator
// Self-checking bench for the bus address allocator. A shadow table of
// occupancy, stored ids, search pointer and entry count predicts every answer;
// a directed opening covers the corner commands, then random phases fill,
// drain and mix the table under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_bus_node_address_allocator import bna_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1350;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic [ADDR_W-1:0] given;
      logic [ID_W-1:0]   sid;
      logic              hit;
      logic              full;
   } alloc_answer_type;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_type;

   class alloc_scoreboard;
      bit                occ[DEPTH];
      logic [ID_W-1:0]   ids[DEPTH];
      logic [ADDR_W-1:0] ptr;
      logic [CNT_W-1:0]  count;
      alloc_answer_type  awaited[$];
      int                errors;

      function new();
         errors = 0;
         clear_table();
      endfunction

      function void clear_table();
         foreach (occ[i]) begin
            occ[i] = 1'b0;
            ids[i] = '0;
         end
         occ[0] = 1'b1;
         ptr    = ADDR_W'(1);
         count  = CNT_W'(1);
      endfunction

      // round-robin step over 1..LIM-1
      function logic [ADDR_W-1:0] step_addr(logic [ADDR_W-1:0] a);
         int s;
         s = int'(a) + 1;
         return (s >= LIM) ? ADDR_W'(1) : ADDR_W'(s);
      endfunction

      function void note_command(logic [1:0] cmd, logic [ID_W-1:0] nid,
                                 logic [ADDR_W-1:0] tgt);
         alloc_answer_type  a;
         logic [ADDR_W-1:0] p;
         a.given = NONE_ADDR;
         a.sid   = '0;
         a.hit   = 1'b0;
         case (cmd)
            CMD_ALLOC: begin
               if (count < LIM_CNT) begin
                  p = ptr;
                  if (p == 0 || p >= LIM) p = ADDR_W'(1);
                  for (int n = 0; n < LIM && occ[p]; n++) p = step_addr(p);
                  if (!occ[p]) begin
                     occ[p]  = 1'b1;
                     ids[p]  = nid;
                     count   = count + CNT_W'(1);
                     a.given = p;
                     ptr     = step_addr(p);
                  end
               end
            end
            CMD_RELEASE: begin
               if (tgt < LIM && occ[tgt]) begin
                  a.hit = 1'b1;
                  // upstream route entry stays held
                  if (tgt != 0) begin
                     occ[tgt] = 1'b0;
                     if (count > 0) count = count - CNT_W'(1);
                  end
               end
            end
            CMD_LOOKUP: begin
               if (tgt < LIM && occ[tgt]) begin
                  a.hit = 1'b1;
                  a.sid = ids[tgt];
               end
            end
            default: clear_table();
         endcase
         a.full = (count >= LIM_CNT);
         awaited.insert(awaited.size(), a);
      endfunction

      task report(string what, int got, int want);
         errors++;
         $display("MISMATCH %0s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      endtask

      task check_response(logic [ADDR_W-1:0] given, logic [ID_W-1:0] sid,
                          logic hit, logic full);
         alloc_answer_type a;
         if (awaited.size() == 0) begin
            report("unexpected item, given_address", given, 0);
         end else begin
            a = awaited.pop_front();
            if (given !== a.given) report("given_address", given, a.given);
            if (sid !== a.sid)     report("stored_id", sid, a.sid);
            if (hit !== a.hit)     report("hit", hit, a.hit);
            if (full !== a.full)   report("table_full", full, a.full);
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   items_sent  = 0;

   bna_req_if req_if();
   bna_rsp_if rsp_if();

   alloc_scoreboard sb = new();

   bus_node_address_allocator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // stall-free windows on each side
   wire req_quiet = (items_sent >= 500) && (items_sent < 800);
   wire rsp_quiet = (cycle_count >= 1800) && (cycle_count < 3000);

   task automatic send_command(logic [1:0] cmd, logic [ID_W-1:0] nid,
                               logic [ADDR_W-1:0] tgt);
      while (!req_quiet && $urandom_range(99) < 20) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.cmd            <= cmd;
      req_if.node_id        <= nid;
      req_if.target_address <= tgt;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_command(cmd, nid, tgt);
      items_sent++;
   endtask

   // mostly held addresses, the rest anywhere in the field
   function automatic logic [ADDR_W-1:0] pick_target();
      int held[$];
      if ($urandom_range(99) < 25) return ADDR_W'($urandom_range(127));
      for (int i = 0; i < DEPTH; i++) begin
         if (sb.occ[i]) held.insert(held.size(), i);
      end
      return ADDR_W'(held[$urandom_range(held.size() - 1)]);
   endfunction

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            sb.check_response(rsp_if.given_address, rsp_if.stored_id,
                              rsp_if.hit, rsp_if.table_full);
         end
         rsp_if.ready <= rsp_quiet || ($urandom_range(99) >= 20);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("bus_node_address_allocator regression: fail");
      $finish;
   end

   initial begin
      phase_type  phase;
      int         span;
      int         roll;
      int         rand_sent;
      logic [1:0] cmd;

      req_if.valid          <= 1'b0;
      req_if.cmd            <= CMD_LOOKUP;
      req_if.node_id        <= '0;
      req_if.target_address <= '0;
      reset                 <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send_command(CMD_LOOKUP,  8'h11, 7'd0);     // upstream route entry
      send_command(CMD_RELEASE, 8'h22, 7'd0);     // never freed
      send_command(CMD_LOOKUP,  8'h33, 7'd0);
      send_command(CMD_LOOKUP,  8'h44, NONE_ADDR);
      send_command(CMD_RELEASE, 8'h55, NONE_ADDR);
      send_command(CMD_RELEASE, 8'h66, 7'd5);     // free address
      send_command(CMD_LOOKUP,  8'h77, 7'd5);
      send_command(CMD_ALLOC,   8'h00, 7'd0);
      send_command(CMD_ALLOC,   8'hFF, NONE_ADDR);
      send_command(CMD_ALLOC,   8'hA5, 7'd42);
      send_command(CMD_LOOKUP,  8'h00, 7'd1);
      send_command(CMD_LOOKUP,  8'hFF, 7'd2);
      send_command(CMD_LOOKUP,  8'h5A, 7'd3);
      send_command(CMD_RELEASE, 8'h00, 7'd2);
      send_command(CMD_ALLOC,   8'h5A, 7'd2);     // pointer moves past the hole
      send_command(CMD_LOOKUP,  8'h00, 7'd2);
      send_command(CMD_RELEASE, 8'h00, 7'd2);
      send_command(CMD_CLEAR,   8'hFF, NONE_ADDR);
      send_command(CMD_LOOKUP,  8'h00, 7'd1);
      send_command(CMD_ALLOC,   8'h3C, 7'd0);
      send_command(CMD_LOOKUP,  8'h00, 7'd1);
      send_command(CMD_RELEASE, 8'h00, 7'd1);

      // random phases; the first one runs long enough to fill the table
      rand_sent = 0;
      phase     = PH_FILL;
      span      = 300;
      while (rand_sent < RANDOM_ITEMS) begin
         for (int k = 0; k < span && rand_sent < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(99);
            case (phase)
               PH_FILL:  cmd = (roll < 85) ? CMD_ALLOC :
                               (roll < 95) ? CMD_LOOKUP : CMD_RELEASE;
               PH_DRAIN: cmd = (roll < 70) ? CMD_RELEASE :
                               (roll < 90) ? CMD_LOOKUP : CMD_ALLOC;
               default:  cmd = (roll < 3)  ? CMD_CLEAR :
                               (roll < 37) ? CMD_ALLOC :
                               (roll < 67) ? CMD_RELEASE : CMD_LOOKUP;
            endcase
            send_command(cmd, ID_W'($urandom_range(255)), pick_target());
            rand_sent++;
         end
         roll  = $urandom_range(2);
         phase = (roll == 0) ? PH_FILL : (roll == 1) ? PH_DRAIN : PH_MIX;
         span  = (phase == PH_FILL) ? $urandom_range(150, 260) : $urandom_range(40, 200);
      end
      req_if.valid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.awaited.size() != 0) sb.report("items left waiting", sb.awaited.size(), 0);

      if (sb.errors == 0) begin
         $display("bus_node_address_allocator regression: pass");
      end else begin
         $display("bus_node_address_allocator regression: fail");
      end
      $finish;
   end

endmodule
